// ===== design/nps_pkg.sv =====
`timescale 1ns / 1ps
package nps_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SEGMENTS = 1024;
  localparam int DEF_CORDIC_STEPS = 16;

  // Projection ratio fraction bits
  localparam int T_BITS = 24;
  localparam logic [39:0] DIST_SAT = 40'hFF_FFFF_FFFF;

  // Request opcodes
  localparam logic [1:0] OP_APPEND   = 2'd0;
  localparam logic [1:0] OP_VARIANCE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_SNAPPED   = 2'd0;
  localparam logic [1:0] ST_THROTTLED = 2'd1;
  localparam logic [1:0] ST_NONE      = 2'd2;

  // Z modes
  localparam logic [1:0] ZM_INPUT = 2'd0;
  localparam logic [1:0] ZM_MAP   = 2'd1;

  // Configuration register indexes
  localparam logic [3:0] REG_SEARCH_RADIUS  = 4'd0;
  localparam logic [3:0] REG_HEADING_FILTER = 4'd1;
  localparam logic [3:0] REG_MAX_HEAD_ERR   = 4'd2;
  localparam logic [3:0] REG_MAX_YAW_VAR    = 4'd3;
  localparam logic [3:0] REG_Z_MODE         = 4'd4;
  localparam logic [3:0] REG_Z_OFFSET       = 4'd5;
  localparam logic [3:0] REG_MIN_PERIOD     = 4'd6;
  localparam logic [3:0] REG_MIN_DISP       = 4'd7;

  // CORDIC arctangent table, 2^24 units per turn
  function automatic logic signed [27:0] atan_lut(input logic [4:0] i);
    logic signed [27:0] v;
    case (i)
      5'd0:  v = 28'sd2097152;
      5'd1:  v = 28'sd1238021;
      5'd2:  v = 28'sd654136;
      5'd3:  v = 28'sd332050;
      5'd4:  v = 28'sd166669;
      5'd5:  v = 28'sd83416;
      5'd6:  v = 28'sd41718;
      5'd7:  v = 28'sd20860;
      5'd8:  v = 28'sd10430;
      5'd9:  v = 28'sd5215;
      5'd10: v = 28'sd2608;
      5'd11: v = 28'sd1304;
      5'd12: v = 28'sd652;
      5'd13: v = 28'sd326;
      5'd14: v = 28'sd163;
      5'd15: v = 28'sd81;
      5'd16: v = 28'sd41;
      5'd17: v = 28'sd20;
      5'd18: v = 28'sd10;
      5'd19: v = 28'sd5;
      5'd20: v = 28'sd3;
      5'd21: v = 28'sd1;
      5'd22: v = 28'sd1;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/nps_seg_mem.sv =====
`timescale 1ns / 1ps
module nps_seg_mem import nps_pkg::*; #(
  parameter int DEPTH = DEF_MAX_SEGMENTS,
  parameter int AW    = $clog2(DEF_MAX_SEGMENTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [191:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [191:0]  rdata
);

  logic [191:0] mem [DEPTH];

  // Write one segment entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nps_div.sv =====
`timescale 1ns / 1ps
module nps_div import nps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        num,
  input  logic [63:0]        den,
  output logic               done,
  output logic [T_BITS-1:0]  quot
);

  localparam int CW = $clog2(T_BITS + 1);

  logic [64:0]       rem_r;
  logic [63:0]       den_r;
  logic [T_BITS-1:0] q_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [64:0]       shl;
  logic              take;

  assign shl  = {rem_r[63:0], 1'b0};
  assign take = shl >= {1'b0, den_r};

  // Sequence one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(T_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= take ? (shl - {1'b0, den_r}) : shl;
      q_r   <= {q_r[T_BITS-2:0], take};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== design/nps_cordic.sv =====
`timescale 1ns / 1ps
module nps_cordic import nps_pkg::*; #(
  parameter int STEPS = DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] x_in,
  input  logic signed [32:0] y_in,
  output logic               done,
  output logic [15:0]        head
);

  localparam int NS = (STEPS < 24) ? STEPS : 24;
  localparam int CW = $clog2(NS + 1);

  logic signed [35:0] x_r, y_r, xs, ys;
  logic signed [27:0] z_r, zr;
  logic [CW-1:0]      cnt_r;
  logic               busy_r, done_r, zero_r;
  logic signed [35:0] xe, ye;

  assign xe = 36'(x_in);
  assign ye = 36'(y_in);
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;

  // Control: run NS micro-rotations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(NS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: prerotate into the right half plane, then rotate
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (x_in == 33'sd0) && (y_in == 33'sd0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r <= ye;
          y_r <= -xe;
          z_r <= 28'sd4194304;
        end else begin
          x_r <= -ye;
          y_r <= xe;
          z_r <= -28'sd4194304;
        end
      end else begin
        x_r <= xe;
        y_r <= ye;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_lut(5'(cnt_r));
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_lut(5'(cnt_r));
      end
    end
  end

  // Round half up to 16 bits
  assign zr   = z_r + 28'sd128;
  assign head = zero_r ? 16'd0 : zr[23:8];
  assign done = done_r;

endmodule

// ===== design/nearest_polyline_segment_snapper_unit.sv =====
`timescale 1ns / 1ps
// Nearest point on a table of centerline segments.
// Requests arrive on in_* (valid/ready). Op append stores one segment in the
// segment memory while the table is not full, op variance sets the current
// yaw variance; neither produces a result. A pose query gives exactly one
// result on out_* (valid/ready): throttled, nothing within radius, or the
// snapped point with heading, z and squared distance.
// Configuration registers are written on cfg_* (valid/ready, always ready)
// by the user only while the block is idle; the block does not enforce it.
// Each segment is read from the memory, then goes through one shared
// multiplier (nine products), the bit-serial 24-step divider for the
// projection ratio and a CORDIC unit running alongside.
// One request is worked on at a time; in_ready is high only between
// requests. A finished result waits in the output register; if the receiver
// stalls, the next query runs up to its result and holds there until the
// previous result is taken.
// Reset (synchronous, rst_n low) empties the table, sets the variance to
// not finite, forgets the last pose and loads register defaults.
module nearest_polyline_segment_snapper_unit import nps_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_end_z,
  input  logic signed [15:0] in_pose_yaw,
  input  logic [31:0]        in_stamp,
  input  logic [31:0]        in_yaw_variance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_snapped_x,
  output logic signed [31:0] out_snapped_y,
  output logic signed [31:0] out_snapped_z,
  output logic signed [15:0] out_heading,
  output logic [39:0]        out_dist_sq,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_THR  = 4'd1;
  localparam logic [3:0] S_THR2 = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_LD   = 4'd4;
  localparam logic [3:0] S_HALF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_TSEL = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_PROJ = 4'd9;
  localparam logic [3:0] S_DSQ  = 4'd10;
  localparam logic [3:0] S_CAND = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Configuration registers
  logic [19:0] radius_r;
  logic        hfilt_r;
  logic [15:0] mhe_r;
  logic [31:0] myv_r;
  logic [1:0]  zmode_r;
  logic signed [31:0] zoff_r;
  logic [31:0] mper_r;
  logic [19:0] mdisp_r;

  // Block state
  logic [3:0]  state_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic [31:0] var_r, last_stamp_r;
  logic signed [31:0] last_x_r, last_y_r;
  logic        has_last_r;

  // Query registers
  logic signed [31:0] px_r, py_r, pz_r;
  logic [15:0] yaw_r;
  logic [31:0] stamp_r;
  logic        allowed_r;
  logic [41:0] dsq_r;
  logic [39:0] md2_r, maxsq_r;
  logic        inr_r;
  logic [1:0]  res_st_r;

  // Segment datapath
  logic signed [33:0] x0_r, y0_r, z0_r;
  logic signed [32:0] vx_r, vy_r, vz_r, sx_r, sy_r, wx_r, wy_r;
  logic [3:0]  step_r;
  logic signed [67:0] prod_r;
  logic signed [63:0] dot_r;
  logic [63:0] len_r;
  logic [T_BITS:0] t_r;
  logic signed [33:0] qx_r, qy_r, qz_r;
  logic [49:0] dacc_r;
  logic [39:0] d2_r;

  // Candidates
  logic        bv_r, av_r;
  logic [39:0] bd_r, ad_r;
  logic signed [33:0] bx_r, by_r, bz_r, ax_r, ay_r, az_r;
  logic [15:0] bh_r, ah_r;

  // Output register
  logic        ov_r;
  logic [1:0]  ost_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic [15:0] oh_r;
  logic [39:0] od_r;

  // Memory and units
  logic [191:0] rdata;
  logic         mem_we;
  logic         cor_done, div_done, div_start;
  logic [15:0]  cor_head;
  logic [T_BITS-1:0] div_q;
  logic signed [32:0] ld_vx, ld_vy;

  logic in_acc;
  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mem_we    = in_acc && (in_op == OP_APPEND) && (cnt_r < CW'(MAX_SEGMENTS));

  nps_seg_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_end_z, in_end_y, in_end_x, in_coord_z, in_coord_y, in_coord_x}),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  assign ld_vx = 33'(signed'(rdata[127:96])) - 33'(signed'(rdata[31:0]));
  assign ld_vy = 33'(signed'(rdata[159:128])) - 33'(signed'(rdata[63:32]));

  nps_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_LD),
    .x_in  (ld_vx),
    .y_in  (ld_vy),
    .done  (cor_done),
    .head  (cor_head)
  );

  nps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dot_r),
    .den   (len_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // Halving test and step toward zero
  function automatic logic big33(input logic signed [32:0] v);
    return (v > 33'sd2147483647) || (v < -33'sd2147483647);
  endfunction
  function automatic logic signed [32:0] half33(input logic signed [32:0] v);
    logic signed [32:0] a;
    a = v + 33'(v[32]);
    return a >>> 1;
  endfunction

  logic any_big;
  assign any_big = big33(sx_r) || big33(sy_r) || big33(wx_r) || big33(wy_r);

  // Pose-to-projection error
  logic signed [33:0] ex, ey;
  logic ex_sat;
  assign ex = 34'(px_r) - qx_r;
  assign ey = 34'(py_r) - qy_r;
  assign ex_sat = (ex >= 34'sd16777216) || (ex <= -34'sd16777216) ||
                  (ey >= 34'sd16777216) || (ey <= -34'sd16777216);

  // Shared multiplier operand select
  logic signed [33:0] ma, mb;
  logic signed [33:0] tt;
  assign tt = 34'(signed'({1'b0, t_r}));
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_MUL: begin
        case (step_r)
          4'd0: begin ma = 34'(sx_r); mb = 34'(wx_r); end
          4'd1: begin ma = 34'(sy_r); mb = 34'(wy_r); end
          4'd2: begin ma = 34'(sx_r); mb = 34'(sx_r); end
          4'd3: begin ma = 34'(sy_r); mb = 34'(sy_r); end
          default: ;
        endcase
      end
      S_PROJ: begin
        case (step_r)
          4'd0: begin ma = tt; mb = 34'(vx_r); end
          4'd1: begin ma = tt; mb = 34'(vy_r); end
          4'd2: begin ma = tt; mb = 34'(vz_r); end
          default: ;
        endcase
      end
      S_DSQ: begin
        case (step_r)
          4'd0: begin ma = ex; mb = ex; end
          4'd1: begin ma = ey; mb = ey; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Rounded projection offset from the registered product
  logic signed [59:0] pr;
  logic signed [33:0] poff;
  assign pr   = prod_r[59:0] + 60'sd8388608;
  assign poff = 34'(pr >>> T_BITS);

  // Heading error and candidate acceptance
  logic [15:0] hdiff;
  logic [16:0] herr;
  logic take_b, take_a;
  assign hdiff  = cor_head - yaw_r;
  assign herr   = hdiff[15] ? (17'd65536 - 17'(hdiff)) : 17'(hdiff);
  assign take_b = (d2_r < maxsq_r) && (!bv_r || d2_r < bd_r);
  assign take_a = allowed_r && (herr <= 17'(mhe_r)) && (d2_r < maxsq_r) &&
                  (!av_r || d2_r < ad_r);

  // Throttle decision
  logic use_p, use_d, skip_p, skip_d, skip;
  logic [31:0] elapsed;
  assign elapsed = stamp_r - last_stamp_r;
  assign use_p   = mper_r != 32'd0;
  assign use_d   = mdisp_r != 20'd0;
  assign skip_p  = use_p && (elapsed < mper_r);
  assign skip_d  = use_d && inr_r && (dsq_r < 42'(md2_r));
  assign skip    = has_last_r && (use_p || use_d) && (!use_p || skip_p) &&
                   (!use_d || skip_d);

  // Throttle movement terms
  logic signed [32:0] tdx, tdy;
  logic signed [20:0] tdxs, tdys;
  assign tdx  = 33'(px_r) - 33'(last_x_r);
  assign tdy  = 33'(py_r) - 33'(last_y_r);
  assign tdxs = tdx[20:0];
  assign tdys = tdy[20:0];

  // Output selection
  logic use_al;
  logic signed [33:0] pk_x, pk_y, pk_z;
  logic [15:0] pk_h;
  logic [39:0] pk_d;
  logic signed [34:0] zsum;
  logic signed [31:0] zout;
  logic last_seg;
  logic out_free;
  assign use_al = allowed_r && av_r;
  assign pk_x = use_al ? ax_r : bx_r;
  assign pk_y = use_al ? ay_r : by_r;
  assign pk_z = use_al ? az_r : bz_r;
  assign pk_h = use_al ? ah_r : bh_r;
  assign pk_d = use_al ? ad_r : bd_r;
  assign zsum = 35'(pk_z) + 35'(zoff_r);
  assign last_seg = (idx_r + 1'b1) == cnt_r;
  assign out_free = !ov_r || out_ready;
  always_comb begin
    case (zmode_r)
      ZM_INPUT: zout = pz_r;
      ZM_MAP: begin
        if (zsum > 35'sd2147483647) zout = 32'sh7FFFFFFF;
        else if (zsum < -35'sd2147483648) zout = 32'sh80000000;
        else zout = zsum[31:0];
      end
      default: zout = zoff_r;
    endcase
  end

  assign div_start = (state_r == S_TSEL) && (dot_r > 0) && (unsigned'(dot_r) < len_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 20'd30000;
      hfilt_r  <= 1'b1;
      mhe_r    <= 16'd18204;
      myv_r    <= 32'd65536;
      zmode_r  <= 2'd2;
      zoff_r   <= '0;
      mper_r   <= 32'd50;
      mdisp_r  <= 20'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEARCH_RADIUS:  radius_r <= cfg_data[19:0];
        REG_HEADING_FILTER: hfilt_r  <= cfg_data[0];
        REG_MAX_HEAD_ERR:   mhe_r    <= cfg_data[15:0];
        REG_MAX_YAW_VAR:    myv_r    <= cfg_data;
        REG_Z_MODE:         zmode_r  <= cfg_data[1:0];
        REG_Z_OFFSET:       zoff_r   <= cfg_data;
        REG_MIN_PERIOD:     mper_r   <= cfg_data;
        REG_MIN_DISP:       mdisp_r  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      idx_r      <= '0;
      var_r      <= 32'hFFFF_FFFF;
      last_stamp_r <= '0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      has_last_r <= 1'b0;
      ov_r       <= 1'b0;
      bv_r       <= 1'b0;
      av_r       <= 1'b0;
      step_r     <= '0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_op)
              OP_APPEND:   if (mem_we) cnt_r <= cnt_r + 1'b1;
              OP_VARIANCE: var_r <= in_yaw_variance;
              OP_QUERY:    state_r <= S_THR;
              default: ;
            endcase
          end
        end
        S_THR: state_r <= S_THR2;
        S_THR2: begin
          idx_r <= '0;
          bv_r  <= 1'b0;
          av_r  <= 1'b0;
          if (skip || cnt_r == '0) state_r <= S_OUT;
          else state_r <= S_RD;
        end
        S_RD: state_r <= S_LD;
        S_LD: state_r <= S_HALF;
        S_HALF: begin
          if (!any_big) begin
            state_r <= S_MUL;
            step_r  <= '0;
          end
        end
        S_MUL: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd4) state_r <= S_TSEL;
        end
        S_TSEL: begin
          step_r <= '0;
          if (div_start) state_r <= S_DIV;
          else state_r <= S_PROJ;
        end
        S_DIV: if (div_done) state_r <= S_PROJ;
        S_PROJ: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd3) begin
            state_r <= S_DSQ;
            step_r  <= '0;
          end
        end
        S_DSQ: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd2) state_r <= S_CAND;
        end
        S_CAND: begin
          if (cor_done) begin
            if (take_b) bv_r <= 1'b1;
            if (take_a) av_r <= 1'b1;
            idx_r <= idx_r + 1'b1;
            state_r <= last_seg ? S_OUT : S_RD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
            if (res_st_r == ST_SNAPPED) begin
              last_stamp_r <= stamp_r;
              last_x_r     <= px_r;
              last_y_r     <= py_r;
              has_last_r   <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          px_r    <= in_coord_x;
          py_r    <= in_coord_y;
          pz_r    <= in_coord_z;
          yaw_r   <= in_pose_yaw;
          stamp_r <= in_stamp;
        end
      end
      S_THR: begin
        inr_r   <= (tdx < 33'sd1048576) && (tdx > -33'sd1048576) &&
                   (tdy < 33'sd1048576) && (tdy > -33'sd1048576);
        dsq_r   <= 42'(tdxs * tdxs) + 42'(tdys * tdys);
        md2_r   <= 40'(mdisp_r) * 40'(mdisp_r);
        maxsq_r <= 40'(radius_r) * 40'(radius_r);
        allowed_r <= hfilt_r && (var_r != 32'd0) && (var_r != 32'hFFFF_FFFF) &&
                     (var_r <= myv_r);
      end
      S_THR2: begin
        res_st_r <= skip ? ST_THROTTLED : ST_NONE;
      end
      S_LD: begin
        x0_r <= 34'(signed'(rdata[31:0]));
        y0_r <= 34'(signed'(rdata[63:32]));
        z0_r <= 34'(signed'(rdata[95:64]));
        vx_r <= ld_vx;
        vy_r <= ld_vy;
        vz_r <= 33'(signed'(rdata[191:160])) - 33'(signed'(rdata[95:64]));
        sx_r <= ld_vx;
        sy_r <= ld_vy;
        wx_r <= 33'(px_r) - 33'(signed'(rdata[31:0]));
        wy_r <= 33'(py_r) - 33'(signed'(rdata[63:32]));
      end
      S_HALF: begin
        if (any_big) begin
          sx_r <= half33(sx_r);
          sy_r <= half33(sy_r);
          wx_r <= half33(wx_r);
          wy_r <= half33(wy_r);
        end
      end
      S_MUL: begin
        case (step_r)
          4'd1: dot_r <= prod_r[63:0];
          4'd2: dot_r <= dot_r + prod_r[63:0];
          4'd3: len_r <= prod_r[63:0];
          4'd4: len_r <= len_r + prod_r[63:0] + 64'd1;
          default: ;
        endcase
      end
      S_TSEL: begin
        if (dot_r <= 0) t_r <= '0;
        else t_r <= (T_BITS+1)'(1) << T_BITS;
      end
      S_DIV: if (div_done) t_r <= {1'b0, div_q};
      S_PROJ: begin
        case (step_r)
          4'd1: qx_r <= x0_r + poff;
          4'd2: qy_r <= y0_r + poff;
          4'd3: qz_r <= z0_r + poff;
          default: ;
        endcase
      end
      S_DSQ: begin
        case (step_r)
          4'd1: dacc_r <= prod_r[49:0];
          4'd2: begin
            if (ex_sat || (dacc_r + prod_r[49:0]) > 50'(DIST_SAT)) d2_r <= DIST_SAT;
            else d2_r <= 40'(dacc_r + prod_r[49:0]);
          end
          default: ;
        endcase
      end
      S_CAND: begin
        if (cor_done) begin
          if (take_b) begin
            bd_r <= d2_r; bx_r <= qx_r; by_r <= qy_r; bz_r <= qz_r; bh_r <= cor_head;
          end
          if (take_a) begin
            ad_r <= d2_r; ax_r <= qx_r; ay_r <= qy_r; az_r <= qz_r; ah_r <= cor_head;
          end
          if (last_seg) res_st_r <= (bv_r || take_b) ? ST_SNAPPED : ST_NONE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ost_r <= res_st_r;
          if (res_st_r == ST_SNAPPED) begin
            ox_r <= pk_x[31:0];
            oy_r <= pk_y[31:0];
            oz_r <= zout;
            oh_r <= pk_h;
            od_r <= pk_d;
          end else begin
            ox_r <= '0;
            oy_r <= '0;
            oz_r <= '0;
            oh_r <= '0;
            od_r <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_snapped_x = ox_r;
  assign out_snapped_y = oy_r;
  assign out_snapped_z = oz_r;
  assign out_heading   = oh_r;
  assign out_dist_sq   = od_r;

`ifndef ASSERT_OFF
  // Table fill never passes its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  // A query request leaves the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_QUERY) |=> !in_ready)
    else $error("query did not start");

  // A pending result is not dropped by a new one
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(ost_r) && $stable(od_r)))
    else $error("stalled result changed");

  // Snapped distances lie inside the search radius, so never equal the saturation value
  a_snap_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r == ST_SNAPPED) |-> (od_r != DIST_SAT))
    else $error("snapped result carries saturated distance");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import nps_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_SEGMENTS;
  localparam int CORDIC_ITERS = DEF_CORDIC_STEPS;
  localparam int IDLE_LIMIT = 250000;
  localparam int RANDOM_ITEMS_PER_PHASE = 62;
  localparam int PHASES = 8;
  localparam int RANDOM_TABLE_CAP = 32;
  localparam longint LIM31 = 64'sd2147483648;
  localparam longint LIM24 = 64'sd16777216;
  localparam longint LIM20 = 64'sd1048576;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] cx, cy, cz, ex, ey, ez;
    logic signed [15:0] yaw;
    logic [31:0]        stamp;
    logic [31:0]        variance;
  } request_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] x, y, z;
    logic signed [15:0] heading;
    logic [39:0]        dist_sq;
  } snap_t;

  typedef struct {
    request_t   req;
    bit         typed;
    logic [1:0] status;
  } dir_row_t;

  typedef struct {
    bit          ok;
    logic [63:0] d2;
    longint      x, y, z;
    logic [15:0] hd;
  } cand_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = OP_APPEND;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic signed [31:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic signed [15:0] in_pose_yaw = '0;
  logic [31:0] in_stamp = '0, in_yaw_variance = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_snapped_x, out_snapped_y, out_snapped_z;
  logic signed [15:0] out_heading;
  logic [39:0] out_dist_sq;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Mirror of the block state and registers
  int          tbl_x0 [TABLE_DEPTH];
  int          tbl_y0 [TABLE_DEPTH];
  int          tbl_z0 [TABLE_DEPTH];
  int          tbl_x1 [TABLE_DEPTH];
  int          tbl_y1 [TABLE_DEPTH];
  int          tbl_z1 [TABLE_DEPTH];
  int unsigned tbl_count = 0;
  logic [31:0] var_now = 32'hFFFF_FFFF;
  logic [31:0] prev_stamp = '0;
  longint      prev_x = 0, prev_y = 0;
  bit          prev_valid = 0;
  logic [19:0] r_radius = 20'd30000;
  logic        r_filter = 1'b1;
  logic [15:0] r_max_err = 16'd18204;
  logic [31:0] r_max_var = 32'd65536;
  logic [1:0]  r_zmode = 2'd2;
  logic signed [31:0] r_zoff = '0;
  logic [31:0] r_period = 32'd50;
  logic [19:0] r_disp = 20'd50;

  longint atan_step [24];

  snap_t    snaps_due [$];
  dir_row_t dir_rows [$];
  int fails = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  logic [31:0] stamp_now = 32'd100000;

  nearest_polyline_segment_snapper_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // CORDIC vectoring of a segment direction, 2^24 units per turn, rounded to 16 bits
  function automatic logic [15:0] seg_heading(longint vx, longint vy);
    longint ax, ay, acc, nx, ny;
    ax = vx;
    ay = vy;
    acc = 0;
    if (ax == 0 && ay == 0) return 16'd0;
    if (ax < 0) begin
      if (ay >= 0) begin
        nx = ay; ny = -ax; acc = 4194304;
      end else begin
        nx = -ay; ny = ax; acc = -4194304;
      end
      ax = nx; ay = ny;
    end
    for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
      if (ay > 0) begin
        nx = ax + (ay >>> i); ny = ay - (ax >>> i); acc = acc + atan_step[i];
      end else begin
        nx = ax - (ay >>> i); ny = ay + (ax >>> i); acc = acc - atan_step[i];
      end
      ax = nx; ay = ny;
    end
    return 16'((acc + 128) >>> 8);
  endfunction

  // Projection ratio in Q24, clamped to 0..1
  function automatic longint ratio_q24(longint dot, logic [63:0] len);
    logic [63:0] rem;
    longint t;
    t = 0;
    if (dot <= 0) return 0;
    if (64'(dot) >= len) return 64'sd1 <<< 24;
    rem = 64'(dot);
    for (int b = 0; b < 24; b++) begin
      rem = rem << 1;
      t = t << 1;
      if (rem >= len) begin
        rem = rem - len;
        t = t | 1;
      end
    end
    return t;
  endfunction

  function automatic cand_t offer(cand_t c, logic [63:0] d2, logic [63:0] lim,
                                  longint x, longint y, longint z, logic [15:0] hd);
    if ((!c.ok || d2 < c.d2) && d2 < lim) begin
      c.ok = 1; c.d2 = d2; c.x = x; c.y = y; c.z = z; c.hd = hd;
    end
    return c;
  endfunction

  // Snap one pose against the mirrored table; update throttle state
  function automatic snap_t snap_pose(request_t r);
    snap_t res;
    cand_t best, aligned, pick;
    longint px, py, pz, x0, y0, z0, vx, vy, vz, sx, sy, wx, wy;
    longint dot, t, qx, qy, qz, ex, ey, dx, dy, zo;
    logic [63:0] len, d2, lim;
    logic [15:0] hd;
    int diff, err;
    bit use_p, use_d, skip_p, skip_d, allowed;
    res = '{default: 0};
    best = '{default: 0};
    aligned = '{default: 0};
    px = r.cx; py = r.cy; pz = r.cz;
    lim = 64'(r_radius) * 64'(r_radius);
    if (prev_valid) begin
      use_p = r_period != 0;
      use_d = r_disp != 0;
      skip_p = use_p && (32'(r.stamp - prev_stamp) < r_period);
      skip_d = 0;
      dx = px - prev_x;
      dy = py - prev_y;
      if (use_d && mag(dx) < LIM20 && mag(dy) < LIM20)
        skip_d = 64'(dx * dx + dy * dy) < 64'(r_disp) * 64'(r_disp);
      if ((use_p || use_d) && (!use_p || skip_p) && (!use_d || skip_d)) begin
        res.status = ST_THROTTLED;
        return res;
      end
    end
    allowed = r_filter && var_now != 0 && var_now != 32'hFFFF_FFFF && var_now <= r_max_var;
    for (int i = 0; i < tbl_count; i++) begin
      x0 = tbl_x0[i]; y0 = tbl_y0[i]; z0 = tbl_z0[i];
      vx = longint'(tbl_x1[i]) - x0;
      vy = longint'(tbl_y1[i]) - y0;
      vz = longint'(tbl_z1[i]) - z0;
      sx = vx; sy = vy; wx = px - x0; wy = py - y0;
      // halve toward zero until the products fit
      while (mag(sx) >= LIM31 || mag(sy) >= LIM31 || mag(wx) >= LIM31 || mag(wy) >= LIM31) begin
        sx = sx / 2; sy = sy / 2; wx = wx / 2; wy = wy / 2;
      end
      dot = sx * wx + sy * wy;
      len = 64'(sx * sx) + 64'(sy * sy) + 64'd1;
      t = ratio_q24(dot, len);
      qx = x0 + ((t * vx + (64'sd1 <<< 23)) >>> 24);
      qy = y0 + ((t * vy + (64'sd1 <<< 23)) >>> 24);
      qz = z0 + ((t * vz + (64'sd1 <<< 23)) >>> 24);
      ex = px - qx;
      ey = py - qy;
      if (mag(ex) >= LIM24 || mag(ey) >= LIM24) begin
        d2 = 64'(DIST_SAT);
      end else begin
        d2 = 64'(ex * ex + ey * ey);
        if (d2 > 64'(DIST_SAT)) d2 = 64'(DIST_SAT);
      end
      hd = seg_heading(vx, vy);
      best = offer(best, d2, lim, qx, qy, qz, hd);
      diff = int'(16'(hd - 16'(r.yaw)));
      err = diff >= 32768 ? 65536 - diff : diff;
      if (allowed && err <= int'(r_max_err))
        aligned = offer(aligned, d2, lim, qx, qy, qz, hd);
    end
    pick = (allowed && aligned.ok) ? aligned : best;
    if (!pick.ok) begin
      res.status = ST_NONE;
      return res;
    end
    if (r_zmode == ZM_INPUT) begin
      zo = pz;
    end else if (r_zmode == ZM_MAP) begin
      zo = pick.z + longint'(r_zoff);
      if (zo > 64'sd2147483647) zo = 64'sd2147483647;
      if (zo < -LIM31) zo = -LIM31;
    end else begin
      zo = r_zoff;
    end
    res.status = ST_SNAPPED;
    res.x = 32'(pick.x);
    res.y = 32'(pick.y);
    res.z = 32'(zo);
    res.heading = pick.hd;
    res.dist_sq = 40'(pick.d2);
    prev_stamp = r.stamp;
    prev_x = px;
    prev_y = py;
    prev_valid = 1;
    return res;
  endfunction

  // Apply an accepted request to the mirror; queue the result a query owes
  task automatic absorb_request(input request_t r, input bit typed, input logic [1:0] st);
    snap_t res;
    if (r.op == OP_APPEND) begin
      if (tbl_count < TABLE_DEPTH) begin
        tbl_x0[tbl_count] = r.cx; tbl_y0[tbl_count] = r.cy; tbl_z0[tbl_count] = r.cz;
        tbl_x1[tbl_count] = r.ex; tbl_y1[tbl_count] = r.ey; tbl_z1[tbl_count] = r.ez;
        tbl_count++;
      end
    end else if (r.op == OP_VARIANCE) begin
      var_now = r.variance;
    end else if (r.op == OP_QUERY) begin
      res = snap_pose(r);
      if (typed) begin
        res = '{default: 0};
        res.status = st;
      end
      snaps_due.push_back(res);
    end
  endtask

  // Send one request in bursts with random gaps between them
  task automatic send_request(input request_t r, input bit typed, input logic [1:0] st);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= r.op;
    in_coord_x <= r.cx; in_coord_y <= r.cy; in_coord_z <= r.cz;
    in_end_x <= r.ex; in_end_y <= r.ey; in_end_z <= r.ez;
    in_pose_yaw <= r.yaw;
    in_stamp <= r.stamp;
    in_yaw_variance <= r.variance;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_request(r, typed, st);
  endtask

  // Hold off the sender until every owed result has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (snaps_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SEARCH_RADIUS:  r_radius = data[19:0];
      REG_HEADING_FILTER: r_filter = data[0];
      REG_MAX_HEAD_ERR:   r_max_err = data[15:0];
      REG_MAX_YAW_VAR:    r_max_var = data;
      REG_Z_MODE:         r_zmode = data[1:0];
      REG_Z_OFFSET:       r_zoff = data;
      REG_MIN_PERIOD:     r_period = data;
      REG_MIN_DISP:       r_disp = data[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] op, input int cx, input int cy, input int cz,
                         input int ex, input int ey, input int ez, input int yaw,
                         input logic [31:0] stamp, input logic [31:0] variance,
                         input bit typed, input logic [1:0] st);
    dir_row_t row;
    row.req = '{op, cx, cy, cz, ex, ey, ez, 16'(yaw), stamp, variance};
    row.typed = typed;
    row.status = st;
    dir_rows.push_back(row);
  endtask

  function automatic int local_coord();
    return int'($urandom_range(0, 100000)) - 50000;
  endfunction

  function automatic logic [31:0] pick3(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      default: return c;
    endcase
  endfunction

  // Random request: mostly well-formed segments and poses near them
  function automatic request_t random_request(bit allow_append);
    request_t r;
    int k, sel;
    r.op = OP_QUERY;
    r.cx = local_coord(); r.cy = local_coord(); r.cz = local_coord();
    r.ex = r.cx + int'($urandom_range(0, 40000)) - 20000;
    r.ey = r.cy + int'($urandom_range(0, 40000)) - 20000;
    r.ez = $urandom;
    r.yaw = $urandom;
    r.variance = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 35 && allow_append) begin
      r.op = OP_APPEND;
      if ($urandom_range(0, 11) == 0) begin
        r.cx = $urandom; r.cy = $urandom; r.ex = $urandom; r.ey = $urandom;
      end
    end else if (sel < 45) begin
      r.op = OP_VARIANCE;
      r.variance = pick3(32'd0, 32'hFFFF_FFFF, $urandom_range(1, 32'h30000));
      if ($urandom_range(0, 3) == 0) r.variance = $urandom;
    end else if (sel < 48) begin
      r.op = 2'd3;
    end else begin
      if (tbl_count > 0 && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, tbl_count - 1);
        r.cx = tbl_x0[k] + int'($urandom_range(0, 60000)) - 30000;
        r.cy = tbl_y0[k] + int'($urandom_range(0, 60000)) - 30000;
        if ($urandom_range(0, 2) == 0) r.yaw = seg_heading(
            longint'(tbl_x1[k]) - tbl_x0[k], longint'(tbl_y1[k]) - tbl_y0[k]);
      end else if ($urandom_range(0, 1) == 0) begin
        r.cx = $urandom; r.cy = $urandom;
      end
      r.cz = $urandom;
      if ($urandom_range(0, 9) == 0) stamp_now = $urandom;
      else stamp_now = stamp_now + $urandom_range(0, 120);
      r.stamp = stamp_now;
    end
    return r;
  endfunction

  // Receiver: ready pattern that switches between always ready, random ready and a periodic window
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 300 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= (rx_cycle % 64) >= 44;
    endcase
  end

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    if (fails < 40)
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    fails++;
  endtask

  // Compare each taken result with the oldest owed one
  always @(posedge clk) begin
    snap_t want;
    if (rst_n && out_valid && out_ready) begin
      if (snaps_due.size() == 0) begin
        if (fails < 40) $display("%0t: result with none owed, status %0d", $time, out_status);
        fails++;
      end else begin
        want = snaps_due.pop_front();
        if (out_status !== want.status) report("status", want.status, out_status);
        if (out_snapped_x !== want.x) report("snapped_x", want.x, out_snapped_x);
        if (out_snapped_y !== want.y) report("snapped_y", want.y, out_snapped_y);
        if (out_snapped_z !== want.z) report("snapped_z", want.z, out_snapped_z);
        if (out_heading !== want.heading) report("heading", want.heading, out_heading);
        if (out_dist_sq !== want.dist_sq) report("dist_sq", want.dist_sq, out_dist_sq);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    request_t r;
    int sent;
    atan_step = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                  10430, 5215, 2608, 1304, 652, 326, 163, 81,
                  41, 20, 10, 5, 3, 1, 1, 0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with reset defaults
    add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 100, 0, 1, ST_NONE);
    add_row(2'd3, 1, 2, 3, 4, 5, 6, 7, 8, 9, 0, ST_SNAPPED);
    add_row(OP_APPEND, 0, 0, 0, 10000, 0, 1000, 0, 0, 0, 0, ST_SNAPPED);
    add_row(OP_APPEND, 0, 1000, 0, 0, 11000, 2000, 0, 0, 0, 0, ST_SNAPPED);
    add_row(OP_APPEND, 5000, 5000, 7, 5000, 5000, 7, 0, 0, 0, 0, ST_SNAPPED);
    add_row(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, ST_SNAPPED);
    add_row(OP_QUERY, 5000, 100, 55, 0, 0, 0, 0, 1000, 0, 0, ST_SNAPPED);
    add_row(OP_QUERY, 5000, 100, 55, 0, 0, 0, 0, 1001, 0, 1, ST_THROTTLED);
    add_row(OP_QUERY, 900000, 900000, -9, 0, 0, 0, 0, 1002, 0, 0, ST_SNAPPED);
    add_row(OP_VARIANCE, 0, 0, 0, 0, 0, 0, 0, 0, 1000, 0, ST_SNAPPED);
    add_row(OP_QUERY, 500, 500, 1, 0, 0, 0, 16384, 5000, 0, 0, ST_SNAPPED);
    add_row(OP_VARIANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_SNAPPED);
    add_row(OP_QUERY, -3000, 200, 2, 0, 0, 0, -32768, 9000, 0, 0, ST_SNAPPED);
    add_row(OP_VARIANCE, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, ST_SNAPPED);
    add_row(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 32767,
            32'hFFFF_FFFF, 0, 0, ST_SNAPPED);
    add_row(OP_QUERY, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, ST_SNAPPED);
    add_row(OP_APPEND, 10000, -5000, 3, -10000, -5000, -3, 0, 0, 0, 0, ST_SNAPPED);
    add_row(OP_QUERY, 0, -4000, 0, 0, 0, 0, -32768, 20000, 0, 0, ST_SNAPPED);
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].status);
    drain_results();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        write_reg(REG_SEARCH_RADIUS, 20'd1000000);
        write_reg(REG_HEADING_FILTER, 32'd1);
        write_reg(REG_MAX_HEAD_ERR, 32'd32768);
        write_reg(REG_MAX_YAW_VAR, 32'hFFFF_FFFE);
        write_reg(REG_Z_MODE, ZM_MAP);
        write_reg(REG_Z_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_MIN_PERIOD, 32'd0);
        write_reg(REG_MIN_DISP, 32'd0);
      end else if (ph == 1) begin
        write_reg(REG_SEARCH_RADIUS, 32'd0);
        write_reg(REG_HEADING_FILTER, 32'd0);
        write_reg(REG_MAX_HEAD_ERR, 32'd0);
        write_reg(REG_MAX_YAW_VAR, 32'd0);
        write_reg(REG_Z_MODE, 32'd3);
        write_reg(REG_Z_OFFSET, 32'h8000_0000);
        write_reg(REG_MIN_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_MIN_DISP, 32'd1000000);
      end else if (ph == 2) begin
        write_reg(REG_SEARCH_RADIUS, 32'd40000);
        write_reg(REG_HEADING_FILTER, 32'd1);
        write_reg(REG_Z_MODE, ZM_MAP);
        write_reg(REG_Z_OFFSET, 32'h8000_0000);
        write_reg(REG_MIN_PERIOD, 32'd30);
        write_reg(REG_MIN_DISP, 32'd2000);
      end else begin
        write_reg(REG_SEARCH_RADIUS, pick3(32'd0, 32'd1000000, $urandom_range(1000, 60000)));
        write_reg(REG_HEADING_FILTER, $urandom_range(0, 1));
        write_reg(REG_MAX_HEAD_ERR, pick3(32'd0, 32'd32768, $urandom_range(0, 32768)));
        write_reg(REG_MAX_YAW_VAR, pick3(32'd0, 32'hFFFF_FFFE, $urandom));
        write_reg(REG_Z_MODE, $urandom_range(0, 3));
        write_reg(REG_Z_OFFSET, pick3(32'h8000_0000, 32'h7FFF_FFFF, $urandom));
        write_reg(REG_MIN_PERIOD, pick3(32'd0, 32'hFFFF_FFFF, $urandom_range(0, 200)));
        write_reg(REG_MIN_DISP, pick3(32'd0, 32'd1000000, $urandom_range(0, 3000)));
      end
      sent = 0;
      while (sent < RANDOM_ITEMS_PER_PHASE) begin
        r = random_request(tbl_count < RANDOM_TABLE_CAP);
        send_request(r, 0, ST_SNAPPED);
        if (r.op != 2'd3) sent++;
        // let everything drain once in the middle of a phase
        if (ph == 3 && sent == 30) drain_results();
      end
      drain_results();
    end

    // Fill the table past its capacity, then scan it whole
    write_reg(REG_MIN_PERIOD, 32'd0);
    write_reg(REG_MIN_DISP, 32'd0);
    write_reg(REG_SEARCH_RADIUS, 32'd1000000);
    sent = 0;
    while (sent < 4) begin
      r = random_request(1);
      r.op = OP_APPEND;
      if (tbl_count == TABLE_DEPTH) sent++;
      send_request(r, 0, ST_SNAPPED);
    end
    for (int q = 0; q < 3; q++) begin
      r = random_request(0);
      r.op = OP_QUERY;
      send_request(r, 0, ST_SNAPPED);
    end
    drain_results();

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nps_pkg.sv
design/nps_seg_mem.sv
design/nps_div.sv
design/nps_cordic.sv
design/nearest_polyline_segment_snapper_unit.sv
sim/tb_top.sv
